[hdl/rc_ppm_frame_encoder_macros.svh]
// Assertion macros shared by the PPM frame encoder RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef RC_PPM_FRAME_ENCODER_MACROS_SVH
`define RC_PPM_FRAME_ENCODER_MACROS_SVH

// same-cycle implication
`define RCPPM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCPPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rcppm_pkg.sv]
// Package for the PPM frame encoder: widths, reset values, codes and shared types.
// No dependencies.
package rcppm_pkg;

    localparam int DEF_MAX_CHANNELS = 16;

    localparam int FRAME_W  = 16;
    localparam int CNT_W    = 5;
    localparam int OFF_W    = 10;
    localparam int SEP_W    = 10;
    localparam int SYNC_W   = 13;
    localparam int VAL_IN_W = 16;
    localparam int VALUE_W  = 11;
    localparam int REM_W    = 13;
    localparam int GAP_W    = 13;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int FRAME_LEN_RST = 22500;
    localparam int CH_COUNT_RST  = 8;
    localparam int OFFSET_RST    = 0;
    localparam int SEP_RST       = 300;
    localparam int SYNC_RST      = 2000;
    localparam int VALUE_MIN     = 1000;
    localparam int VALUE_MAX     = 2000;
    localparam int VALUE_RST     = 1500;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        SEG_SYNC = 2'd0,
        SEG_GAP  = 2'd1,
        SEG_SEP  = 2'd2,
        SEG_FILL = 2'd3
    } seg_kind_t;

    typedef enum logic [2:0] {
        REG_FRAME_LENGTH  = 3'd0,
        REG_CHANNEL_COUNT = 3'd1,
        REG_PULSE_OFFSET  = 3'd2,
        REG_SEPARATOR     = 3'd3,
        REG_SYNC          = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic        [FRAME_W-1:0] frame_length_us;
        logic        [CNT_W-1:0]   channel_count;
        logic signed [OFF_W-1:0]   pulse_offset;
        logic        [SEP_W-1:0]   separator_us;
        logic        [SYNC_W-1:0]  sync_us;
    } cfg_t;

    typedef struct packed {
        logic               level;
        logic               frame_start;
        logic [VALUE_W-1:0] read_value;
    } result_t;

endpackage

[hdl/rcppm_core.sv]
// Frame state and channel tables of the PPM frame encoder; one word per go strobe.
// Depends on rcppm_pkg and rc_ppm_frame_encoder_macros.svh.
`include "rc_ppm_frame_encoder_macros.svh"

module rcppm_core
    import rcppm_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [1:0]          cmd,
    input  logic [CNT_W-1:0]    channel_index,
    input  logic [VAL_IN_W-1:0] channel_value,
    input  cfg_t                cfg,
    output result_t             result
);

    localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W = (CH_W > CNT_W) ? CH_W : CNT_W;
    localparam logic [IDX_W-1:0] SECOND_IDX = IDX_W'((MAX_CHANNELS > 1) ? 1 : 0);

    typedef struct packed {
        seg_kind_t         kind;
        logic [REM_W-1:0]  rem;
        logic [CH_W-1:0]   chan;
    } seg_t;

    seg_kind_t                            kind_reg, kind_next;
    logic [REM_W-1:0]                     rem_reg, rem_next;
    logic [CH_W-1:0]                      chan_reg, chan_next;
    logic [FRAME_W-1:0]                   pos_reg, pos_next;
    logic [MAX_CHANNELS-1:0][VALUE_W-1:0] pending_reg, pending_next;
    logic [MAX_CHANNELS-1:0][VALUE_W-1:0] active_reg, active_next;

    logic [CH_W-1:0]    used;
    logic               fs;
    seg_t               cur, nxt;
    logic [CH_W-1:0]    chan_plus;
    logic [CH_W-1:0]    addr_b;
    logic [VALUE_W-1:0] val_b;
    logic [FRAME_W:0]   pos_inc;
    logic [FRAME_W-1:0] flen;
    logic               idx_ok;
    logic [IDX_W-1:0]   acc_idx;
    logic [VALUE_W-1:0] wr_value;
    logic [VALUE_W-1:0] rd_value;

    // index into the tables, out-of-range addresses fold to entry 0
    function automatic logic [IDX_W-1:0] to_idx(input logic [CMP_W-1:0] a);
        return (a < CMP_W'(MAX_CHANNELS)) ? a[IDX_W-1:0] : '0;
    endfunction

    // enter the low gap of channel ch (fill past the used count); a non-positive gap falls to the separator
    function automatic seg_t enter_gap(
        input logic [CH_W-1:0]         ch,
        input logic [VALUE_W-1:0]      v,
        input logic [CH_W-1:0]         n_used,
        input logic [SEP_W-1:0]        sep,
        input logic signed [OFF_W-1:0] off
    );
        seg_t                    s;
        logic signed [GAP_W-1:0] g;
        g = GAP_W'(signed'({1'b0, v})) - GAP_W'(signed'({1'b0, sep})) + GAP_W'(off);
        s.chan = ch;
        if (ch >= n_used)
        begin
            s.kind = SEG_FILL;
            s.rem  = '0;
        end
        else if (g > 0)
        begin
            s.kind = SEG_GAP;
            s.rem  = REM_W'(unsigned'(g));
        end
        else
        begin
            s.kind = SEG_SEP;
            s.rem  = REM_W'(sep);
        end
        return s;
    endfunction

    always_comb
    begin
        if (CMP_W'(cfg.channel_count) > CMP_W'(MAX_CHANNELS))
            used = CH_W'(MAX_CHANNELS);
        else
            used = CH_W'(cfg.channel_count);
    end

    // segment in force on this tick (frame start re-enters the sync mark, or the gap of channel 0 when sync_us is zero)
    always_comb
    begin
        fs = (pos_reg == '0);
        if (fs)
        begin
            if (cfg.sync_us != '0)
                cur = '{kind: SEG_SYNC, rem: REM_W'(cfg.sync_us), chan: '0};
            else
                cur = enter_gap('0, pending_reg[0], used, cfg.separator_us,
                                cfg.pulse_offset);
        end
        else
        begin
            cur = '{kind: kind_reg, rem: rem_reg, chan: chan_reg};
        end
    end

    // value of the channel the next gap may need; at frame start the tables
    // are being copied, so read the pending side
    always_comb
    begin
        chan_plus = cur.chan + CH_W'(1);
        addr_b    = (cur.kind == SEG_SYNC) ? cur.chan : chan_plus;
        if (fs)
            val_b = (cur.kind == SEG_SYNC) ? pending_reg[0] : pending_reg[SECOND_IDX];
        else
            val_b = active_reg[to_idx(CMP_W'(addr_b))];
    end

    always_comb
    begin
        nxt = cur;
        if (cur.kind != SEG_FILL)
        begin
            if (cur.rem <= REM_W'(1))
            begin
                case (cur.kind)
                    SEG_SYNC:
                        nxt = enter_gap(cur.chan, val_b, used, cfg.separator_us,
                                        cfg.pulse_offset);
                    SEG_GAP:
                    begin
                        if (cfg.separator_us != '0)
                            nxt = '{kind: SEG_SEP, rem: REM_W'(cfg.separator_us),
                                    chan: cur.chan};
                        else
                            nxt = enter_gap(chan_plus, val_b, used, cfg.separator_us,
                                            cfg.pulse_offset);
                    end
                    SEG_SEP:
                        nxt = enter_gap(chan_plus, val_b, used, cfg.separator_us,
                                        cfg.pulse_offset);
                    default:
                        nxt = cur;
                endcase
            end
            else
            begin
                nxt.rem = cur.rem - REM_W'(1);
            end
        end
    end

    always_comb
    begin
        flen    = (cfg.frame_length_us == '0) ? FRAME_W'(1) : cfg.frame_length_us;
        pos_inc = {1'b0, pos_reg} + (FRAME_W + 1)'(1);
    end

    always_comb
    begin
        idx_ok  = CMP_W'(channel_index) < CMP_W'(used);
        acc_idx = to_idx(CMP_W'(channel_index));
        if (channel_value < VAL_IN_W'(VALUE_MIN))
            wr_value = VALUE_W'(VALUE_MIN);
        else if (channel_value > VAL_IN_W'(VALUE_MAX))
            wr_value = VALUE_W'(VALUE_MAX);
        else
            wr_value = channel_value[VALUE_W-1:0];
        rd_value = idx_ok ? pending_reg[acc_idx] : '0;
    end

    always_comb
    begin
        kind_next    = kind_reg;
        rem_next     = rem_reg;
        chan_next    = chan_reg;
        pos_next     = pos_reg;
        pending_next = pending_reg;
        active_next  = active_reg;
        result       = '0;
        case (cmd_t'(cmd))
            CMD_TICK:
            begin
                result.level       = (cur.kind == SEG_SYNC) || (cur.kind == SEG_SEP);
                result.frame_start = fs;
                if (go)
                begin
                    kind_next = nxt.kind;
                    rem_next  = nxt.rem;
                    chan_next = nxt.chan;
                    pos_next  = (pos_inc >= {1'b0, flen}) ? '0 : pos_inc[FRAME_W-1:0];
                    if (fs)
                        active_next = pending_reg;
                end
            end
            CMD_WRITE:
            begin
                if (go && idx_ok)
                    pending_next[acc_idx] = wr_value;
            end
            CMD_READ:
            begin
                result.read_value = rd_value;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= SEG_SYNC;
            rem_reg  <= '0;
            chan_reg <= '0;
            pos_reg  <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                pending_reg[i] <= VALUE_W'(VALUE_RST);
                active_reg[i]  <= VALUE_W'(VALUE_RST);
            end
        end
        else
        begin
            kind_reg    <= kind_next;
            rem_reg     <= rem_next;
            chan_reg    <= chan_next;
            pos_reg     <= pos_next;
            pending_reg <= pending_next;
            active_reg  <= active_next;
        end
    end

    `RCPPM_ASSERT_IMPL(a_seg_live, (pos_reg != '0) && (kind_reg != SEG_FILL), rem_reg != '0, "live segment with zero length")
    `RCPPM_ASSERT_NEXT(a_frame_copy, go && (cmd == CMD_TICK) && (pos_reg == '0), active_reg == $past(pending_reg), "active table not loaded at frame start")
    `RCPPM_ASSERT_NEXT(a_pos_hold, go && (cmd != CMD_TICK), $stable(pos_reg), "frame position moved on a non-tick word")
    `RCPPM_ASSERT_IMPL(a_pend_range, 1'b1, (pending_reg[0] >= VALUE_W'(VALUE_MIN)) && (pending_reg[0] <= VALUE_W'(VALUE_MAX)), "pending value out of range")

endmodule

[hdl/rc_ppm_frame_encoder.sv]
// Top level of the PPM frame encoder: APB register file, input and result registers.
// Depends on rcppm_pkg, rcppm_core and rc_ppm_frame_encoder_macros.svh.
//
//   channel   handshake                 payload
//   -------   -----------------------   --------------------------------------
//   in        in_valid / in_ready       cmd, channel_index, channel_value
//   out       out_valid / out_ready     level, frame_start, read_value
//   apb       psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// One word per cycle sustained while out_ready stays high; a word taken waits in the input
// register, then moves to the result register, from which it leaves.
// The rate is set by the segment update in rcppm_core, which is combinational.
// Reset loads the register defaults and 1500 into every channel slot; the frame starts
// on the first tick. A stalled output holds its word and the input register keeps one more.
`include "rc_ppm_frame_encoder_macros.svh"

module rc_ppm_frame_encoder
    import rcppm_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [CNT_W-1:0]    channel_index,
    input  logic [VAL_IN_W-1:0] channel_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                level,
    output logic                frame_start,
    output logic [VALUE_W-1:0]  read_value
);

    cfg_t                cfg_reg, cfg_next;
    logic                s1_valid_reg, s1_valid_next;
    logic [1:0]          s1_cmd_reg;
    logic [CNT_W-1:0]    s1_idx_reg;
    logic [VAL_IN_W-1:0] s1_val_reg;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg;
    result_t             core_result;
    logic                advance;
    logic                in_take;
    logic                cfg_wr;
    reg_idx_t            reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_sel)
                REG_FRAME_LENGTH:  cfg_next.frame_length_us = pwdata[FRAME_W-1:0];
                REG_CHANNEL_COUNT: cfg_next.channel_count   = pwdata[CNT_W-1:0];
                REG_PULSE_OFFSET:  cfg_next.pulse_offset    = signed'(pwdata[OFF_W-1:0]);
                REG_SEPARATOR:     cfg_next.separator_us    = pwdata[SEP_W-1:0];
                REG_SYNC:          cfg_next.sync_us         = pwdata[SYNC_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_LENGTH:  prdata = DATA_W'(cfg_reg.frame_length_us);
            REG_CHANNEL_COUNT: prdata = DATA_W'(cfg_reg.channel_count);
            REG_PULSE_OFFSET:  prdata = DATA_W'(unsigned'(cfg_reg.pulse_offset));
            REG_SEPARATOR:     prdata = DATA_W'(cfg_reg.separator_us);
            REG_SYNC:          prdata = DATA_W'(cfg_reg.sync_us);
            default:           prdata = '0;
        endcase
    end

    // input register moves on when the result register is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_length_us <= FRAME_W'(FRAME_LEN_RST);
            cfg_reg.channel_count   <= CNT_W'(CH_COUNT_RST);
            cfg_reg.pulse_offset    <= OFF_W'(OFFSET_RST);
            cfg_reg.separator_us    <= SEP_W'(SEP_RST);
            cfg_reg.sync_us         <= SYNC_W'(SYNC_RST);
            s1_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg <= cmd;
            s1_idx_reg <= channel_index;
            s1_val_reg <= channel_value;
        end
        if (advance)
            out_reg <= core_result;
    end

    rcppm_core #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (advance),
        .cmd           (s1_cmd_reg),
        .channel_index (s1_idx_reg),
        .channel_value (s1_val_reg),
        .cfg           (cfg_reg),
        .result        (core_result)
    );

    assign out_valid   = out_valid_reg;
    assign level       = out_reg.level;
    assign frame_start = out_reg.frame_start;
    assign read_value  = out_reg.read_value;

    `RCPPM_ASSERT_IMPL(a_stall_full, !in_ready, s1_valid_reg && out_valid_reg && !out_ready, "input blocked with room in the pipe")
    `RCPPM_ASSERT_NEXT(a_adv_loads, advance, out_valid_reg && !s1_valid_reg || out_valid_reg && $past(in_take), "word lost between registers")
    `RCPPM_ASSERT_NEXT(a_take_holds, in_take, s1_valid_reg, "accepted word not held")

endmodule
